// File: sv/walk_on_spheres_laplace_solver_assert.svh
// Assertion helpers used by the checker file.
`ifndef WALK_ON_SPHERES_LAPLACE_SOLVER_ASSERT_SVH
`define WALK_ON_SPHERES_LAPLACE_SOLVER_ASSERT_SVH

// Same-cycle implication, clocked on clk, quiet while rst_n is low.
`define WOS_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WOS_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

// File: sv/wos_pkg.sv
`default_nettype none
package wos_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int ANGLE_BITS = 12;
  localparam int REST_BITS  = ANGLE_BITS - 2;
  localparam int POS_W      = 18;
  localparam int DIST_W     = 19;
  localparam int SUM_W      = 36;
  localparam int DIV_STEPS  = SUM_W;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [63:0] RECIP_NUM   = 64'd1 << 32;

  // register map, word index
  localparam logic [1:0] REG_PATHS = 2'd0;
  localparam logic [1:0] REG_LIMIT = 2'd1;
  localparam logic [1:0] REG_TOL   = 2'd2;

  // datapath commands
  localparam logic [4:0] OP_NOP  = 5'd0;
  localparam logic [4:0] OP_LOAD = 5'd1;
  localparam logic [4:0] OP_DRAW = 5'd2;
  localparam logic [4:0] OP_M_TH = 5'd3;
  localparam logic [4:0] OP_W_TH = 5'd4;
  localparam logic [4:0] OP_M_X2 = 5'd5;
  localparam logic [4:0] OP_W_X2 = 5'd6;
  localparam logic [4:0] OP_M_XT = 5'd7;
  localparam logic [4:0] OP_M_RC = 5'd8;
  localparam logic [4:0] OP_W_T  = 5'd9;
  localparam logic [4:0] OP_M_TS = 5'd10;
  localparam logic [4:0] OP_W_S  = 5'd11;
  localparam logic [4:0] OP_W_C  = 5'd12;
  localparam logic [4:0] OP_M_RX = 5'd13;
  localparam logic [4:0] OP_W_X  = 5'd14;
  localparam logic [4:0] OP_M_RY = 5'd15;
  localparam logic [4:0] OP_W_Y  = 5'd16;
  localparam logic [4:0] OP_M_XX = 5'd17;
  localparam logic [4:0] OP_W_XX = 5'd18;
  localparam logic [4:0] OP_M_YY = 5'd19;
  localparam logic [4:0] OP_W_G  = 5'd20;
  localparam logic [4:0] OP_DIV  = 5'd21;
  localparam logic [4:0] OP_EMIT = 5'd22;

  typedef struct packed {
    logic [4:0] op;
    logic       cosine;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic near;
    logic walk_over;
    logic solve_over;
    logic div_done;
    logic out_free;
  } stat_t;

  // Horner divisors of the sine and cosine series
  function automatic logic [7:0] series_div(input logic cosine, input logic [2:0] idx);
    logic [7:0] d;
    case (idx)
      3'd0:    d = cosine ? 8'd132 : 8'd110;
      3'd1:    d = cosine ? 8'd90  : 8'd72;
      3'd2:    d = cosine ? 8'd56  : 8'd42;
      3'd3:    d = cosine ? 8'd30  : 8'd20;
      3'd4:    d = cosine ? 8'd12  : 8'd6;
      default: d = 8'd2;
    endcase
    return d;
  endfunction

  // floor(2^32 / d) for the same divisors
  function automatic logic [31:0] series_recip(input logic cosine, input logic [2:0] idx);
    logic [31:0] m;
    case (idx)
      3'd0:    m = cosine ? 32'(RECIP_NUM / 64'd132) : 32'(RECIP_NUM / 64'd110);
      3'd1:    m = cosine ? 32'(RECIP_NUM / 64'd90)  : 32'(RECIP_NUM / 64'd72);
      3'd2:    m = cosine ? 32'(RECIP_NUM / 64'd56)  : 32'(RECIP_NUM / 64'd42);
      3'd3:    m = cosine ? 32'(RECIP_NUM / 64'd30)  : 32'(RECIP_NUM / 64'd20);
      3'd4:    m = cosine ? 32'(RECIP_NUM / 64'd12)  : 32'(RECIP_NUM / 64'd6);
      default: m = 32'(RECIP_NUM / 64'd2);
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// File: sv/walk_on_spheres_laplace_solver.sv
`default_nettype none
// Walk-on-spheres estimate of the harmonic function on the unit square with
// boundary values x*x - y*y, in signed fixed point with 16 fraction bits.
// A start beat (command 0) loads a point; each draw beat (command 1) gives
// one random angle. The block takes one beat at a time. A draw that moves the
// walker runs the sine and cosine series as 11 multiply-and-correct steps on
// one shared 33x33 multiplier; a draw that ends a walk, and a start that
// already lies within tolerance, also run the steps for the boundary value.
// A finished point goes through the bit-serial mean divider before the mean
// is shown on the output register, which holds it while out_stall is high.
module walk_on_spheres_laplace_solver (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  in_command,
  input  wire logic signed [wos_pkg::POS_W-1:0]      in_point_x,
  input  wire logic signed [wos_pkg::POS_W-1:0]      in_point_y,
  input  wire logic [wos_pkg::ANGLE_BITS-1:0]        in_angle,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [wos_pkg::POS_W-1:0]           out_mean_value,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [3:0]                            paddr,
  input  wire logic [31:0]                           pwdata,
  output logic [31:0]                                prdata,
  output logic                                       pready
);
  import wos_pkg::*;

  logic [15:0] paths_r;
  logic [7:0]  limit_r;
  logic [15:0] tol_r;
  cmd_t        cmd;
  stat_t       stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paths_r <= 16'd256;
      limit_r <= 8'd128;
      tol_r   <= 16'd66;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_PATHS: paths_r <= pwdata[15:0];
        REG_LIMIT: limit_r <= pwdata[7:0];
        REG_TOL:   tol_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PATHS: prdata = {16'd0, paths_r};
      REG_LIMIT: prdata = {24'd0, limit_r};
      REG_TOL:   prdata = {16'd0, tol_r};
      default:   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  wos_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  wos_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_angle        (in_angle),
    .paths_per_point (paths_r),
    .step_limit      (limit_r),
    .edge_tolerance  (tol_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_mean_value  (out_mean_value)
  );

endmodule
`default_nettype wire

// File: sv/wos_div.sv
`default_nettype none
module wos_div (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire logic signed [wos_pkg::SUM_W-1:0] dividend,
  input  wire logic [16:0]                     divisor,
  output logic                                 done,
  output logic signed [wos_pkg::SUM_W:0]       quotient
);
  import wos_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [16:0]       rem_r, rem_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [16:0]       dvs_r, dvs_nxt;
  logic              neg_r, neg_nxt;
  logic [17:0]       sh;
  logic [17:0]       diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    sh       = {rem_r, quo_r[SUM_W-1]};
    diff     = sh - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      neg_nxt  = dividend[SUM_W-1];
      quo_nxt  = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    end else if (busy_r) begin
      // restoring step, one quotient bit per cycle
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = diff[16:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = sh[16:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

endmodule
`default_nettype wire

// File: sv/wos_dp.sv
`default_nettype none
module wos_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire wos_pkg::cmd_t                       cmd,
  output wos_pkg::stat_t                           stat,
  input  wire logic signed [wos_pkg::POS_W-1:0]    in_point_x,
  input  wire logic signed [wos_pkg::POS_W-1:0]    in_point_y,
  input  wire logic [wos_pkg::ANGLE_BITS-1:0]      in_angle,
  input  wire logic [15:0]                         paths_per_point,
  input  wire logic [7:0]                          step_limit,
  input  wire logic [15:0]                         edge_tolerance,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [wos_pkg::POS_W-1:0]         out_mean_value
);
  import wos_pkg::*;

  localparam logic signed [19:0] ONE = 20'sd1 << FRAC_BITS;
  localparam int RND = 30 - FRAC_BITS;

  logic signed [POS_W-1:0]  wx_r, wy_r, ox_r, oy_r;
  logic [7:0]               moves_r;
  logic [15:0]              walks_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic [ANGLE_BITS-1:0]    angle_r;
  logic [DIST_W-1:0]        r_r;
  logic [30:0]              th_r;
  logic [31:0]              x2_r;
  logic [30:0]              t_r;
  logic [31:0]              p_r;
  logic [16:0]              sin_r, cos_r;
  logic signed [65:0]       prod_r;
  logic signed [SUM_W-1:0]  gxx_r;
  logic                     out_valid_r;
  logic signed [POS_W-1:0]  out_mean_r;

  logic [DIST_W-1:0]        r_cur;
  logic signed [32:0]       op_a, op_b;
  logic [7:0]               dconst;
  logic [31:0]              q0;
  logic [39:0]              rem;
  logic [32:0]              q;
  logic [32:0]              rnd_s, rnd_c;
  logic signed [17:0]       c_pos, s_pos, c_sig, s_sig;
  logic signed [22:0]       step, nxt_pos;
  logic signed [POS_W-1:0]  sat_pos;
  logic signed [36:0]       gdiff;
  logic signed [36:0]       gval;
  logic                     div_done;
  logic signed [SUM_W:0]    quo;
  logic [16:0]              divisor;

  function automatic logic [DIST_W-1:0] edge_dist(input logic signed [POS_W-1:0] x,
                                                  input logic signed [POS_W-1:0] y);
    logic signed [19:0] v0, v1, v2, v3;
    logic [DIST_W-1:0]  a0, a1, a2, a3, m;
    v0 = 20'(x) - ONE;
    v1 = 20'(x);
    v2 = 20'(y) - ONE;
    v3 = 20'(y);
    a0 = v0[19] ? DIST_W'(-v0) : DIST_W'(v0);
    a1 = v1[19] ? DIST_W'(-v1) : DIST_W'(v1);
    a2 = v2[19] ? DIST_W'(-v2) : DIST_W'(v2);
    a3 = v3[19] ? DIST_W'(-v3) : DIST_W'(v3);
    m = a0;
    if (a1 < m) m = a1;
    if (a2 < m) m = a2;
    if (a3 < m) m = a3;
    return m;
  endfunction

  assign r_cur = edge_dist(wx_r, wy_r);

  // quadrant map of the first-quadrant cosine and sine
  always_comb begin
    c_pos = $signed({1'b0, cos_r});
    s_pos = $signed({1'b0, sin_r});
    case (angle_r[ANGLE_BITS-1 -: 2])
      2'd0:    begin c_sig = c_pos;  s_sig = s_pos;  end
      2'd1:    begin c_sig = -s_pos; s_sig = c_pos;  end
      2'd2:    begin c_sig = -c_pos; s_sig = -s_pos; end
      default: begin c_sig = s_pos;  s_sig = -c_pos; end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.op)
      OP_M_TH: begin op_a = $signed(33'(angle_r[REST_BITS-1:0]));
                     op_b = $signed(33'(HALF_PI_Q30)); end
      OP_M_X2: begin op_a = $signed(33'(th_r));  op_b = $signed(33'(th_r)); end
      OP_M_XT: begin op_a = $signed(33'(x2_r));  op_b = $signed(33'(t_r));  end
      OP_M_RC: begin op_a = $signed(33'(prod_r[61:30]));
                     op_b = $signed(33'(series_recip(cmd.cosine, cmd.idx))); end
      OP_M_TS: begin op_a = $signed(33'(th_r));  op_b = $signed(33'(t_r));  end
      OP_M_RX: begin op_a = $signed(33'(r_r));   op_b = 33'(c_sig);         end
      OP_M_RY: begin op_a = $signed(33'(r_r));   op_b = 33'(s_sig);         end
      OP_M_XX: begin op_a = 33'(wx_r);           op_b = 33'(wx_r);          end
      OP_M_YY: begin op_a = 33'(wy_r);           op_b = 33'(wy_r);          end
      default: begin op_a = '0;                  op_b = '0;                 end
    endcase
  end

  always_comb begin
    // p / d by reciprocal, then at most one correction
    dconst = series_div(cmd.cosine, cmd.idx);
    q0     = prod_r[63:32];
    rem    = {8'd0, p_r} - (40'(q0) * 40'(dconst));
    q      = 33'(q0) + ((rem >= 40'(dconst)) ? 33'd1 : 33'd0);
    rnd_s  = 33'(prod_r[61:30]) + (33'd1 << (RND - 1));
    rnd_c  = 33'(t_r) + (33'd1 << (RND - 1));
    step   = 23'(prod_r >>> FRAC_BITS);
    nxt_pos = (cmd.op == OP_W_Y) ? 23'(wy_r) + step : 23'(wx_r) + step;
    if (nxt_pos > 23'sd131071)       sat_pos = 18'sd131071;
    else if (nxt_pos < -23'sd131072) sat_pos = -18'sd131072;
    else                             sat_pos = nxt_pos[POS_W-1:0];
    gdiff  = 37'(gxx_r) - 37'($signed(prod_r[35:0]));
    gval   = gdiff >>> FRAC_BITS;
  end

  assign divisor = (walks_r == 16'd0) ? 17'h10000 : {1'b0, walks_r};

  wos_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == OP_DIV),
    .dividend (sum_r),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        wx_r <= in_point_x;  ox_r <= in_point_x;
        wy_r <= in_point_y;  oy_r <= in_point_y;
        moves_r <= '0;  walks_r <= '0;  sum_r <= '0;
      end
      OP_DRAW: begin
        angle_r <= in_angle;
        r_r     <= r_cur;
      end
      OP_M_TH, OP_M_X2, OP_M_XT, OP_M_TS, OP_M_RX, OP_M_RY, OP_M_XX, OP_M_YY:
        prod_r <= op_a * op_b;
      OP_M_RC: begin
        prod_r <= op_a * op_b;
        p_r    <= prod_r[61:30];
      end
      OP_W_TH: th_r <= prod_r[REST_BITS +: 31];
      OP_W_X2: begin
        x2_r <= prod_r[61:30];
        t_r  <= Q30_ONE;
      end
      OP_W_T:  t_r <= (q >= 33'(Q30_ONE)) ? 31'd0 : 31'(33'(Q30_ONE) - q);
      OP_W_S: begin
        sin_r <= rnd_s[RND +: 17];
        t_r   <= Q30_ONE;
      end
      OP_W_C:  cos_r <= rnd_c[RND +: 17];
      OP_W_X:  wx_r <= sat_pos;
      OP_W_Y: begin
        wy_r    <= sat_pos;
        moves_r <= moves_r + 8'd1;
      end
      OP_W_XX: gxx_r <= prod_r[SUM_W-1:0];
      OP_W_G: begin
        sum_r   <= sum_r + SUM_W'(gval);
        walks_r <= walks_r + 16'd1;
        wx_r    <= ox_r;
        wy_r    <= oy_r;
        moves_r <= '0;
      end
      OP_EMIT: begin
        if (quo > 37'sd131071)       out_mean_r <= 18'sd131071;
        else if (quo < -37'sd131072) out_mean_r <= -18'sd131072;
        else                         out_mean_r <= quo[POS_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.near       = r_cur < DIST_W'(edge_tolerance);
  assign stat.walk_over  = (r_cur < DIST_W'(edge_tolerance)) || !(moves_r < step_limit);
  assign stat.solve_over = (walks_r >= paths_per_point) || (walks_r == 16'd0);
  assign stat.div_done   = div_done;
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_mean_value = out_mean_r;

endmodule
`default_nettype wire

// File: sv/wos_ctrl.sv
`default_nettype none
module wos_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_command,
  output logic                in_stall,
  input  wire wos_pkg::stat_t stat,
  output wos_pkg::cmd_t       cmd
);
  import wos_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_START = 5'd1;
  localparam logic [4:0] S_DRAW  = 5'd2;
  localparam logic [4:0] S_M_TH  = 5'd3;
  localparam logic [4:0] S_W_TH  = 5'd4;
  localparam logic [4:0] S_M_X2  = 5'd5;
  localparam logic [4:0] S_W_X2  = 5'd6;
  localparam logic [4:0] S_M_XT  = 5'd7;
  localparam logic [4:0] S_M_RC  = 5'd8;
  localparam logic [4:0] S_W_T   = 5'd9;
  localparam logic [4:0] S_M_TS  = 5'd10;
  localparam logic [4:0] S_W_S   = 5'd11;
  localparam logic [4:0] S_W_C   = 5'd12;
  localparam logic [4:0] S_M_RX  = 5'd13;
  localparam logic [4:0] S_W_X   = 5'd14;
  localparam logic [4:0] S_M_RY  = 5'd15;
  localparam logic [4:0] S_W_Y   = 5'd16;
  localparam logic [4:0] S_CHECK = 5'd17;
  localparam logic [4:0] S_M_XX  = 5'd18;
  localparam logic [4:0] S_W_XX  = 5'd19;
  localparam logic [4:0] S_M_YY  = 5'd20;
  localparam logic [4:0] S_W_G   = 5'd21;
  localparam logic [4:0] S_FIN   = 5'd22;
  localparam logic [4:0] S_DIV   = 5'd23;
  localparam logic [4:0] S_EMIT  = 5'd24;

  logic [4:0] state_r, state_nxt;
  logic       solving_r, solving_nxt;
  logic       start_r, start_nxt;
  logic       cos_r, cos_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [4:0] op;

  always_comb begin
    state_nxt   = state_r;
    solving_nxt = solving_r;
    start_nxt   = start_r;
    cos_nxt     = cos_r;
    idx_nxt     = idx_r;
    op          = OP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_command) begin
            op          = OP_LOAD;
            start_nxt   = 1'b1;
            solving_nxt = 1'b0;
            state_nxt   = S_START;
          end else if (solving_r) begin
            op        = OP_DRAW;
            start_nxt = 1'b0;
            state_nxt = S_DRAW;
          end
        end
      end
      S_START: begin
        if (stat.near) begin
          state_nxt = S_M_XX;
        end else begin
          solving_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      // walker already on the edge: end the walk without a move
      S_DRAW:  state_nxt = stat.near ? S_M_XX : S_M_TH;
      S_M_TH:  begin op = OP_M_TH; state_nxt = S_W_TH; end
      S_W_TH:  begin op = OP_W_TH; state_nxt = S_M_X2; end
      S_M_X2:  begin op = OP_M_X2; state_nxt = S_W_X2; end
      S_W_X2: begin
        op        = OP_W_X2;
        cos_nxt   = 1'b0;
        idx_nxt   = '0;
        state_nxt = S_M_XT;
      end
      S_M_XT:  begin op = OP_M_XT; state_nxt = S_M_RC; end
      S_M_RC:  begin op = OP_M_RC; state_nxt = S_W_T;  end
      S_W_T: begin
        op = OP_W_T;
        if (idx_r == (cos_r ? 3'd5 : 3'd4)) begin
          state_nxt = cos_r ? S_W_C : S_M_TS;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = S_M_XT;
        end
      end
      S_M_TS:  begin op = OP_M_TS; state_nxt = S_W_S; end
      S_W_S: begin
        op        = OP_W_S;
        cos_nxt   = 1'b1;
        idx_nxt   = '0;
        state_nxt = S_M_XT;
      end
      S_W_C:   begin op = OP_W_C;  state_nxt = S_M_RX; end
      S_M_RX:  begin op = OP_M_RX; state_nxt = S_W_X;  end
      S_W_X:   begin op = OP_W_X;  state_nxt = S_M_RY; end
      S_M_RY:  begin op = OP_M_RY; state_nxt = S_W_Y;  end
      S_W_Y:   begin op = OP_W_Y;  state_nxt = S_CHECK; end
      S_CHECK: state_nxt = stat.walk_over ? S_M_XX : S_IDLE;
      S_M_XX:  begin op = OP_M_XX; state_nxt = S_W_XX; end
      S_W_XX:  begin op = OP_W_XX; state_nxt = S_M_YY; end
      S_M_YY:  begin op = OP_M_YY; state_nxt = S_W_G;  end
      S_W_G:   begin op = OP_W_G;  state_nxt = S_FIN;  end
      S_FIN: begin
        if (start_r || stat.solve_over) begin
          op          = OP_DIV;
          solving_nxt = 1'b0;
          state_nxt   = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV:   if (stat.div_done) state_nxt = S_EMIT;
      S_EMIT: begin
        if (stat.out_free) begin
          op        = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      solving_r <= 1'b0;
      start_r   <= 1'b0;
      cos_r     <= 1'b0;
      idx_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      solving_r <= solving_nxt;
      start_r   <= start_nxt;
      cos_r     <= cos_nxt;
      idx_r     <= idx_nxt;
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign cmd.op     = op;
  assign cmd.cosine = cos_r;
  assign cmd.idx    = idx_r;

endmodule
`default_nettype wire

// File: sv/wos_checker.sv
`default_nettype none
`include "walk_on_spheres_laplace_solver_assert.svh"
module wos_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        in_command,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [17:0] out_mean_value,
  input wire logic        pready
);
  logic out_held;
  logic start_beat;

  assign out_held   = out_valid && out_stall;
  assign start_beat = in_valid && !in_stall && !in_command;

  `WOS_ASSERT_NOW(a_pready_high, 1'b1, pready, "pready dropped")
  `WOS_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_mean_value), "mean moved")
  `WOS_ASSERT_NEXT(a_start_busy, start_beat, in_stall, "start beat did not occupy the block")
  `WOS_ASSERT_NOW(a_emit_from_busy, $rose(out_valid), $past(in_stall), "mean appeared while idle")
endmodule

bind walk_on_spheres_laplace_solver wos_checker u_wos_checker (.*);
`default_nettype wire
